>>> hdl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned VALUE_BITS_DEFAULT = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic find;
        logic dec;
        logic sel_sign;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done;
        logic negative;
        logic idx_zero;
    } status_t;

endpackage

>>> hdl/sitda_in_if.sv
// ----------------------------------------------------------------------------
// sitda_in_if
// Input channel: one signed integer per item, with valid and ready.
// ----------------------------------------------------------------------------
interface sitda_in_if #(
    parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> hdl/sitda_out_if.sv
// ----------------------------------------------------------------------------
// sitda_out_if
// Output channel: one ASCII character per item, with the last flag.
// ----------------------------------------------------------------------------
interface sitda_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

>>> hdl/sitda_datapath.sv
// ----------------------------------------------------------------------------
// sitda_datapath
// Magnitude, shift-and-add-3 BCD conversion four bits a cycle, leading digit
// search and character selection.
// ----------------------------------------------------------------------------
module sitda_datapath #(
    parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sitda_pkg::cmd_t        cmd,
    input  logic [VALUE_BITS-1:0]  value,
    output sitda_pkg::status_t     status,
    output logic [7:0]             character,
    output logic                   last
);
    import sitda_pkg::*;

    localparam int unsigned STEPS = (VALUE_BITS + 3) / 4;
    localparam int unsigned MAG_W = STEPS * 4;
    // Upper bound on the decimal digits of 2^(VALUE_BITS-1) over the range.
    localparam int unsigned NDIG  = (VALUE_BITS * 3) / 10 + 1;
    localparam int unsigned BCD_W = NDIG * 4;
    localparam int unsigned IW    = $clog2(NDIG);
    localparam int unsigned SCW   = $clog2(STEPS);

    logic [MAG_W-1:0]      mag_reg,  mag_next;
    logic [BCD_W-1:0]      bcd_reg,  bcd_next;
    logic [IW-1:0]         idx_reg,  idx_next;
    logic [SCW-1:0]        step_reg, step_next;
    logic                  neg_reg,  neg_next;

    logic [VALUE_BITS-1:0] abs_val;
    logic [BCD_W-1:0]      bcd_step;
    logic [IW-1:0]         lead;
    logic [3:0]            digit;

    // The most negative value negates to itself, which read as unsigned is
    // exactly its magnitude.
    assign abs_val = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

    always_comb
    begin
        logic [BCD_W-1:0] b;
        b = bcd_reg;
        for (int j = 0; j < 4; j++)
        begin
            for (int d = 0; d < int'(NDIG); d++)
            begin
                if (b[4*d +: 4] >= 4'd5)
                begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], mag_reg[MAG_W-1-j]};
        end
        bcd_step = b;
    end

    always_comb
    begin
        lead = '0;
        for (int d = 1; d < int'(NDIG); d++)
        begin
            if (bcd_reg[4*d +: 4] != 4'd0)
            begin
                lead = IW'(d);
            end
        end
    end

    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        idx_next  = idx_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        if (cmd.load)
        begin
            mag_next  = MAG_W'(abs_val);
            bcd_next  = '0;
            step_next = SCW'(STEPS - 1);
            neg_next  = value[VALUE_BITS-1];
        end
        if (cmd.step)
        begin
            mag_next  = {mag_reg[MAG_W-5:0], 4'b0000};
            bcd_next  = bcd_step;
            step_next = step_reg - 1'b1;
        end
        if (cmd.find)
        begin
            idx_next = lead;
        end
        if (cmd.dec)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign digit            = bcd_reg[4*idx_reg +: 4];
    assign status.conv_done = (step_reg == '0);
    assign status.negative  = neg_reg;
    assign status.idx_zero  = (idx_reg == '0);
    assign character        = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, digit});
    assign last             = !cmd.sel_sign && (idx_reg == '0);

endmodule

>>> hdl/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer for load, conversion, leading digit search and character output.
// ----------------------------------------------------------------------------
module sitda_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  sitda_pkg::status_t status,
    output sitda_pkg::cmd_t    cmd
);
    import sitda_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (status.conv_done)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                state_next = status.negative ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_ready && status.idx_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
            end
            ST_FIND:
            begin
                cmd.find = 1'b1;
            end
            ST_SIGN:
            begin
                out_valid    = 1'b1;
                cmd.sel_sign = 1'b1;
            end
            ST_DIGIT:
            begin
                out_valid = 1'b1;
                cmd.dec   = out_ready && !status.idx_zero;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character per item.
// ----------------------------------------------------------------------------
// One integer is taken at a time. After it is accepted the magnitude runs
// through a shift-and-add-3 BCD converter that consumes four bits a cycle,
// followed by the ST_FIND state that locates the leading digit. Then a '-'
// for a negative value and the digits leave, most significant first, one
// character a cycle while the sink is ready; the final character carries
// last. The input is ready again in the cycle after the last character.
// Zero gives a single '0' and the most negative value is converted exactly.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int unsigned VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    sitda_in_if.sink    num,
    sitda_out_if.source text
);
    import sitda_pkg::*;

    cmd_t    cmd;
    status_t status;

    sitda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num.valid),
        .in_ready  (num.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sitda_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (num.value[VALUE_BITS-1:0]),
        .status    (status),
        .character (text.character),
        .last      (text.last)
    );

    // No character is offered while a new number can be taken.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(num.ready && text.valid))
        else $error("character offered while input is ready");

    // Once a number is taken, the input stays closed in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (num.valid && num.ready) |=> !num.ready)
        else $error("input ready directly after an accepted item");

    // The final character hands control back to the input side.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && text.last) |=> (num.ready && !text.valid))
        else $error("block not idle after the last character");

    // Only a minus sign or a decimal digit is ever produced.
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid |-> (text.character == CHAR_MINUS ||
                        (text.character >= CHAR_ZERO && text.character <= CHAR_NINE)))
        else $error("character outside the decimal set");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to decimal text converter.
// Integers are sent in bursts with random gaps, and the text side stalls on
// its own pattern. Each character is checked against a queue of characters
// predicted from every accepted integer.
// ----------------------------------------------------------------------------
module tb;
    import sitda_pkg::*;

    localparam int unsigned VALUE_BITS  = VALUE_BITS_DEFAULT;
    localparam int unsigned MAX_DIGITS  = 20;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RANDOM_ITEMS = 328;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    logic clk;
    logic rst_n;

    sitda_in_if #(.VALUE_BITS(VALUE_BITS)) num_if ();
    sitda_out_if text_if ();

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .num  (num_if),
        .text (text_if)
    );

    text_char_t expected_text[$];
    int         error_count;
    int         cycle_count;
    int         burst_left;
    bit         gaps_off;
    bit         stall_off;
    int         stall_left;
    int         stall_pct;

    always #1 clk = ~clk;

    // Pushes the characters that one integer should produce.
    function automatic void predict_text(input logic signed [VALUE_BITS-1:0] v);
        longint          magnitude;
        byte unsigned    digits[MAX_DIGITS];
        int              count;
        bit              negative;
        text_char_t      entry;

        negative  = v[VALUE_BITS-1];
        magnitude = negative ? -longint'(v) : longint'(v);
        count     = 0;
        do
        begin
            digits[count] = byte'(magnitude % 10);
            magnitude     = magnitude / 10;
            count++;
        end
        while (magnitude != 0 && count < MAX_DIGITS);

        if (negative)
        begin
            entry.character = CHAR_MINUS;
            entry.last      = 1'b0;
            expected_text.push_back(entry);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            entry.character = 8'(CHAR_ZERO + digits[i]);
            entry.last      = (i == 0);
            expected_text.push_back(entry);
        end
    endfunction

    // Sends one integer, opening a random gap when the current burst runs out.
    task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
        int gap;

        if (!gaps_off && burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40)
                                              : $urandom_range(0, 6);
            if (gap > 0)
            begin
                num_if.valid <= 1'b0;
                num_if.value <= $urandom;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        num_if.valid <= 1'b1;
        num_if.value <= v;
        @(posedge clk);
        while (!num_if.ready)
            @(posedge clk);
        predict_text(v);
        burst_left--;
    endtask

    task automatic apply_reset();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    // Boundaries of the digit count, both signs, every digit and the most
    // negative value.
    task automatic test_extremes();
        logic signed [VALUE_BITS-1:0] values[$];

        values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                   32'sd2147483647, -32'sd2147483647, 32'h8000_0000,
                   32'sd999999999, 32'sd1000000000, -32'sd1000000000,
                   -32'sd999999999, 32'sd123456789, -32'sd987654321,
                   32'sd1073741824, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (values[i])
            send_value(values[i]);
    endtask

    // Items back to back with the text side always ready.
    task automatic test_back_to_back();
        gaps_off  = 1'b1;
        stall_off = 1'b1;
        repeat (30)
            send_value($urandom);
        gaps_off  = 1'b0;
        stall_off = 1'b0;
    endtask

    task automatic test_random_mixed();
        longint unsigned              pow10[11];
        longint unsigned              lo;
        longint unsigned              hi;
        longint unsigned              mag;
        logic signed [VALUE_BITS-1:0] v;
        int                           nd;
        bit                           neg;

        pow10[0] = 1;
        for (int k = 1; k <= 10; k++)
            pow10[k] = pow10[k-1] * 10;

        repeat (RANDOM_ITEMS)
        begin
            neg = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9)) inside
                [0:3]:
                    v = $urandom;
                [4:7]:
                begin
                    // Spread the digit count evenly rather than by magnitude.
                    nd  = $urandom_range(1, 10);
                    lo  = (nd == 1) ? 0 : pow10[nd-1];
                    hi  = pow10[nd] - 1;
                    if (nd == 10)
                        hi = neg ? 64'd2147483648 : 64'd2147483647;
                    mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
                    v   = VALUE_BITS'(neg ? -mag : mag);
                end
                8:
                begin
                    mag = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
                    v   = VALUE_BITS'(neg ? -mag : mag);
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 0;
                        1: v = neg ? -1 : 1;
                        2: v = 32'sd2147483647;
                        default: v = 32'h8000_0000;
                    endcase
                end
            endcase
            send_value(v);
        end
    endtask

    // Text side: stall bursts whose density is redrawn each time the low byte of cycle_count returns to zero.
    always @(posedge clk)
    begin
        if (cycle_count[7:0] == 8'd0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 10;
                2: stall_pct = 40;
                default: stall_pct = 70;
            endcase
        end
        if (stall_off)
            text_if.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            text_if.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            text_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end
        else
            text_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        text_char_t want;

        if (rst_n && text_if.valid && text_if.ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("character %h with no item outstanding", text_if.character);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_if.character !== want.character)
                begin
                    $error("character: expected %h, actual %h",
                           want.character, text_if.character);
                    error_count++;
                end
                if (text_if.last !== want.last)
                begin
                    $error("last: expected %b, actual %b", want.last, text_if.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        num_if.valid  = 1'b0;
        num_if.value  = '0;
        text_if.ready = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        burst_left    = 0;
        gaps_off      = 1'b0;
        stall_off     = 1'b0;
        stall_left    = 0;
        stall_pct     = 0;

        apply_reset();
        test_extremes();
        test_back_to_back();
        test_random_mixed();

        num_if.valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        // Leave room for any stray character after the last expected one.
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
